// ----- hdl/ddo_pkg.sv -----
`default_nettype none
package ddo_pkg;

   // Register indexes on the configuration channel.
   localparam logic [3:0] REG_WHEEL_RADIUS  = 4'd0;
   localparam logic [3:0] REG_HALF_TRACK    = 4'd1;
   localparam logic [3:0] REG_SPEED_LIMIT   = 4'd2;
   localparam logic [3:0] REG_TIME_STEP     = 4'd3;
   localparam logic [3:0] REG_WHEELS_READY  = 4'd4;
   localparam logic [3:0] REG_START_X       = 4'd5;
   localparam logic [3:0] REG_START_Y       = 4'd6;
   localparam logic [3:0] REG_START_HEADING = 4'd7;

   localparam int          QUOT_BITS  = 31;
   localparam logic [30:0] MAG_MAX    = 31'h7FFF_FFFF;
   localparam logic [33:0] RAD_TO_BAM = 34'd683565276;
   localparam longint      GAIN_Q30   = 64'd652032875;

   typedef struct packed {
      logic        done;
      logic [30:0] quot;
   } div_res_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/ddo_if.sv -----
`default_nettype none
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] left_speed;
   logic signed [31:0] right_speed;
   logic signed [31:0] linear_speed;
   logic signed [31:0] angular_speed;

   modport source (output valid, func, left_speed, right_speed, linear_speed,
                   angular_speed, input ready);
   modport sink (input valid, func, left_speed, right_speed, linear_speed,
                 angular_speed, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [15:0]        heading;
   logic               moved;
   logic               was_scaled;

   modport source (output valid, pos_x, pos_y, heading, moved, was_scaled,
                   input ready);
   modport sink (input valid, pos_x, pos_y, heading, moved, was_scaled,
                 output ready);
endinterface

interface ddo_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/diff_drive_odometry.sv -----
`default_nettype none
// Channel    Direction  Carries
// req_chan   in         func, left/right wheel speeds, linear/angular speed
// rsp_chan   out        pos_x, pos_y, heading, moved, was_scaled
// csr_chan   in         register index and write data
//
// A word takes longer with angular commands and with scaling than with wheel
// speeds in range; the divider serves every division, one pass each, with one
// shared multiplier for the other steps.
// Reset is synchronous; geometry and pose go to their reset values.
// A finished word waits in the output register while the next one is taken.
module diff_drive_odometry #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ddo_req_if.sink    req_chan,
   ddo_rsp_if.source  rsp_chan,
   ddo_csr_if.sink    csr_chan
);
   localparam int DW  = 64 + FRAC_BITS;
   localparam int CW  = FRAC_BITS + 3;
   localparam int HSH = 2 * FRAC_BITS - 16;

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_BW_MUL  = 6'd1;
   localparam logic [5:0] S_BW_ADD  = 6'd2;
   localparam logic [5:0] S_DL_GO   = 6'd3;
   localparam logic [5:0] S_DL_WAIT = 6'd4;
   localparam logic [5:0] S_DR_GO   = 6'd5;
   localparam logic [5:0] S_DR_WAIT = 6'd6;
   localparam logic [5:0] S_MAG     = 6'd7;
   localparam logic [5:0] S_SL_MUL  = 6'd8;
   localparam logic [5:0] S_SL_GO   = 6'd9;
   localparam logic [5:0] S_SL_WAIT = 6'd10;
   localparam logic [5:0] S_SR_MUL  = 6'd11;
   localparam logic [5:0] S_SR_GO   = 6'd12;
   localparam logic [5:0] S_SR_WAIT = 6'd13;
   localparam logic [5:0] S_SUM     = 6'd14;
   localparam logic [5:0] S_V_MUL   = 6'd15;
   localparam logic [5:0] S_V       = 6'd16;
   localparam logic [5:0] S_W_MUL   = 6'd17;
   localparam logic [5:0] S_W_GO    = 6'd18;
   localparam logic [5:0] S_W_WAIT  = 6'd19;
   localparam logic [5:0] S_XC_MUL  = 6'd20;
   localparam logic [5:0] S_XC      = 6'd21;
   localparam logic [5:0] S_XD_MUL  = 6'd22;
   localparam logic [5:0] S_XD      = 6'd23;
   localparam logic [5:0] S_YS_MUL  = 6'd24;
   localparam logic [5:0] S_YS      = 6'd25;
   localparam logic [5:0] S_YD_MUL  = 6'd26;
   localparam logic [5:0] S_YD      = 6'd27;
   localparam logic [5:0] S_P_MUL   = 6'd28;
   localparam logic [5:0] S_P       = 6'd29;
   localparam logic [5:0] S_TH_MUL  = 6'd30;
   localparam logic [5:0] S_TH      = 6'd31;
   localparam logic [5:0] S_TL_MUL  = 6'd32;
   localparam logic [5:0] S_T       = 6'd33;
   localparam logic [5:0] S_FIN     = 6'd34;

   logic [5:0] state_ff;

   // Configuration.
   logic [30:0] radius_ff, track_ff, limit_ff;
   logic [16:0] dt_ff;
   logic        wready_ff;
   logic [30:0] r_eff, b_eff, lim_eff;

   // Pose.
   logic signed [31:0] cur_x_ff, cur_y_ff;
   logic [15:0]        cur_h_ff;

   // Working registers.
   logic               moved_ff, scaled_ff;
   logic signed [31:0] in_v_ff, in_w_ff;
   logic signed [55:0] num_l_ff, num_r_ff;
   logic signed [31:0] wl_ff, wr_ff, v_ff;
   logic [31:0]        ml_ff, mr_ff, mx_ff;
   logic               ln_ff, rn_ff, sum_neg_ff, dif_neg_ff;
   logic [32:0]        msum_ff, mdif_ff;
   logic [30:0]        wm_ff;
   logic signed [33:0] t1_ff;
   logic [47:0]        p_ff, th_ff;

   // Output register.
   logic               rsp_valid_ff, out_moved_ff, out_scaled_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [15:0]        out_h_ff;

   // Shared multiplier.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff, prod_sh;

   // Divider and CORDIC hookup.
   logic                 div_start;
   logic [DW-1:0]        div_dividend;
   logic [31:0]          div_divisor;
   ddo_pkg::div_res_type div_res;
   logic                 cor_start, cor_done;
   logic signed [CW-1:0] cor_cos, cor_sin;

   // Combinational helpers.
   logic signed [55:0] bw, num_l, num_r;
   logic [55:0]        mag_l, mag_r;
   logic [31:0]        ml, mr, mx;
   logic signed [32:0] sum, dif;
   logic [67:0]        vsh;
   logic [30:0]        vmag;
   logic signed [51:0] step, pos_sum;
   logic signed [31:0] pos_sat;
   logic [47:0]        tsum, tsh;
   logic [15:0]        dh;
   logic               req_fire;
   logic               fin_load;

   assign r_eff   = (radius_ff == 31'd0) ? 31'd1 : radius_ff;
   assign b_eff   = (track_ff == 31'd0) ? 31'd1 : track_ff;
   assign lim_eff = (limit_ff == 31'd0) ? 31'd1 : limit_ff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The finished word moves to the output register once that register is free.
   assign fin_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BW_MUL: begin
            mul_a = {3'b000, b_eff};
            mul_b = {{2{in_w_ff[31]}}, in_w_ff};
         end
         S_SL_MUL: begin
            mul_a = {2'b00, ml_ff};
            mul_b = {3'b000, lim_eff};
         end
         S_SR_MUL: begin
            mul_a = {2'b00, mr_ff};
            mul_b = {3'b000, lim_eff};
         end
         S_V_MUL: begin
            mul_a = {3'b000, r_eff};
            mul_b = {1'b0, msum_ff};
         end
         S_W_MUL: begin
            mul_a = {3'b000, r_eff};
            mul_b = {1'b0, mdif_ff};
         end
         S_XC_MUL: begin
            mul_a = {{2{v_ff[31]}}, v_ff};
            mul_b = 34'(cor_cos);
         end
         S_YS_MUL: begin
            mul_a = {{2{v_ff[31]}}, v_ff};
            mul_b = 34'(cor_sin);
         end
         S_XD_MUL, S_YD_MUL: begin
            mul_a = t1_ff;
            mul_b = {17'd0, dt_ff};
         end
         S_P_MUL: begin
            mul_a = {3'b000, wm_ff};
            mul_b = {17'd0, dt_ff};
         end
         S_TH_MUL: begin
            mul_a = {18'd0, p_ff[47:32]};
            mul_b = ddo_pkg::RAD_TO_BAM;
         end
         S_TL_MUL: begin
            mul_a = {2'b00, p_ff[31:0]};
            mul_b = ddo_pkg::RAD_TO_BAM;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign bw      = prod_sh[55:0];
   assign num_l   = {{24{in_v_ff[31]}}, in_v_ff} + bw;
   assign num_r   = {{24{in_v_ff[31]}}, in_v_ff} - bw;
   assign mag_l   = num_l_ff[55] ? 56'(-num_l_ff) : 56'(num_l_ff);
   assign mag_r   = num_r_ff[55] ? 56'(-num_r_ff) : 56'(num_r_ff);

   assign ml = wl_ff[31] ? 32'(-wl_ff) : 32'(wl_ff);
   assign mr = wr_ff[31] ? 32'(-wr_ff) : 32'(wr_ff);
   assign mx = (ml > mr) ? ml : mr;

   assign sum = {wl_ff[31], wl_ff} + {wr_ff[31], wr_ff};
   assign dif = {wl_ff[31], wl_ff} - {wr_ff[31], wr_ff};

   assign vsh  = prod_ff >> (FRAC_BITS + 1);
   assign vmag = (vsh > 68'(ddo_pkg::MAG_MAX)) ? ddo_pkg::MAG_MAX : vsh[30:0];

   assign step    = prod_sh[51:0];
   assign pos_sum = ((state_ff == S_XD) ? {{20{cur_x_ff[31]}}, cur_x_ff}
                                        : {{20{cur_y_ff[31]}}, cur_y_ff}) + step;
   assign pos_sat = (pos_sum > 52'sd2147483647) ? 32'sh7FFF_FFFF :
                    (pos_sum < -52'sd2147483648) ? 32'sh8000_0000 : pos_sum[31:0];

   assign tsum = th_ff + {16'd0, prod_ff[63:32]};
   assign tsh  = tsum >> HSH;
   assign dh   = dif_neg_ff ? 16'(-tsh[15:0]) : tsh[15:0];

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_DL_GO: begin
            div_start    = 1'b1;
            div_dividend = {{(DW-56-FRAC_BITS){1'b0}}, mag_l, {FRAC_BITS{1'b0}}};
            div_divisor  = {1'b0, r_eff};
         end
         S_DR_GO: begin
            div_start    = 1'b1;
            div_dividend = {{(DW-56-FRAC_BITS){1'b0}}, mag_r, {FRAC_BITS{1'b0}}};
            div_divisor  = {1'b0, r_eff};
         end
         S_SL_GO, S_SR_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(prod_ff[63:0]);
            div_divisor  = mx_ff;
         end
         S_W_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(prod_ff[63:0]);
            div_divisor  = {b_eff, 1'b0};
         end
         default: begin
            div_start    = 1'b0;
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   assign cor_start = req_fire && wready_ff;

   ddo_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   ddo_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cur_h_ff),
      .done  (cor_done),
      .cos_o (cor_cos),
      .sin_o (cor_sin)
   );

   // Sequencer and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (!wready_ff)           state_ff <= S_FIN;
                  else if (req_chan.func)   state_ff <= S_BW_MUL;
                  else                      state_ff <= S_MAG;
               end
            end
            S_BW_MUL:  state_ff <= S_BW_ADD;
            S_BW_ADD:  state_ff <= S_DL_GO;
            S_DL_GO:   state_ff <= S_DL_WAIT;
            S_DL_WAIT: if (div_res.done) state_ff <= S_DR_GO;
            S_DR_GO:   state_ff <= S_DR_WAIT;
            S_DR_WAIT: if (div_res.done) state_ff <= S_MAG;
            S_MAG:     state_ff <= ({1'b0, mx} > {2'b00, lim_eff}) ? S_SL_MUL : S_SUM;
            S_SL_MUL:  state_ff <= S_SL_GO;
            S_SL_GO:   state_ff <= S_SL_WAIT;
            S_SL_WAIT: if (div_res.done) state_ff <= S_SR_MUL;
            S_SR_MUL:  state_ff <= S_SR_GO;
            S_SR_GO:   state_ff <= S_SR_WAIT;
            S_SR_WAIT: if (div_res.done) state_ff <= S_SUM;
            S_SUM:     state_ff <= S_V_MUL;
            S_V_MUL:   state_ff <= S_V;
            S_V:       state_ff <= S_W_MUL;
            S_W_MUL:   state_ff <= S_W_GO;
            S_W_GO:    state_ff <= S_W_WAIT;
            S_W_WAIT:  if (div_res.done) state_ff <= S_XC_MUL;
            S_XC_MUL:  if (cor_done) state_ff <= S_XC;
            S_XC:      state_ff <= S_XD_MUL;
            S_XD_MUL:  state_ff <= S_XD;
            S_XD:      state_ff <= S_YS_MUL;
            S_YS_MUL:  state_ff <= S_YS;
            S_YS:      state_ff <= S_YD_MUL;
            S_YD_MUL:  state_ff <= S_YD;
            S_YD:      state_ff <= S_P_MUL;
            S_P_MUL:   state_ff <= S_P;
            S_P:       state_ff <= S_TH_MUL;
            S_TH_MUL:  state_ff <= S_TH;
            S_TH:      state_ff <= S_TL_MUL;
            S_TL_MUL:  state_ff <= S_T;
            S_T:       state_ff <= S_FIN;
            S_FIN:     if (fin_load) state_ff <= S_IDLE;
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               in_v_ff   <= req_chan.linear_speed;
               in_w_ff   <= req_chan.angular_speed;
               wl_ff     <= req_chan.left_speed;
               wr_ff     <= req_chan.right_speed;
               moved_ff  <= wready_ff;
               scaled_ff <= 1'b0;
            end
         end
         S_BW_ADD: begin
            num_l_ff <= num_l;
            num_r_ff <= num_r;
         end
         S_DL_WAIT: begin
            if (div_res.done) begin
               wl_ff <= num_l_ff[55] ? -{1'b0, div_res.quot} : {1'b0, div_res.quot};
            end
         end
         S_DR_WAIT: begin
            if (div_res.done) begin
               wr_ff <= num_r_ff[55] ? -{1'b0, div_res.quot} : {1'b0, div_res.quot};
            end
         end
         S_MAG: begin
            ml_ff     <= ml;
            mr_ff     <= mr;
            mx_ff     <= mx;
            ln_ff     <= wl_ff[31];
            rn_ff     <= wr_ff[31];
            scaled_ff <= ({1'b0, mx} > {2'b00, lim_eff});
         end
         S_SL_WAIT: begin
            if (div_res.done) begin
               wl_ff <= ln_ff ? -{1'b0, div_res.quot} : {1'b0, div_res.quot};
            end
         end
         S_SR_WAIT: begin
            if (div_res.done) begin
               wr_ff <= rn_ff ? -{1'b0, div_res.quot} : {1'b0, div_res.quot};
            end
         end
         S_SUM: begin
            sum_neg_ff <= sum[32];
            dif_neg_ff <= dif[32];
            msum_ff    <= sum[32] ? 33'(-sum) : 33'(sum);
            mdif_ff    <= dif[32] ? 33'(-dif) : 33'(dif);
         end
         S_V: begin
            v_ff <= sum_neg_ff ? -{1'b0, vmag} : {1'b0, vmag};
         end
         S_W_WAIT: begin
            if (div_res.done) begin
               wm_ff <= div_res.quot;
            end
         end
         S_XC, S_YS: begin
            t1_ff <= prod_sh[33:0];
         end
         S_P: begin
            p_ff <= prod_ff[47:0];
         end
         S_TH: begin
            th_ff <= prod_ff[47:0];
         end
         S_FIN: begin
            if (fin_load) begin
               out_x_ff      <= cur_x_ff;
               out_y_ff      <= cur_y_ff;
               out_h_ff      <= cur_h_ff;
               out_moved_ff  <= moved_ff;
               out_scaled_ff <= scaled_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration and pose; a start value written also loads the pose.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd65536;
         track_ff  <= 31'd65536;
         limit_ff  <= 31'd65536;
         dt_ff     <= 17'd655;
         wready_ff <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         cur_h_ff  <= '0;
      end else begin
         if (state_ff == S_XD) cur_x_ff <= pos_sat;
         if (state_ff == S_YD) cur_y_ff <= pos_sat;
         if (state_ff == S_T)  cur_h_ff <= cur_h_ff + dh;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               ddo_pkg::REG_WHEEL_RADIUS:  radius_ff <= csr_chan.data[30:0];
               ddo_pkg::REG_HALF_TRACK:    track_ff  <= csr_chan.data[30:0];
               ddo_pkg::REG_SPEED_LIMIT:   limit_ff  <= csr_chan.data[30:0];
               ddo_pkg::REG_TIME_STEP:     dt_ff     <= csr_chan.data[16:0];
               ddo_pkg::REG_WHEELS_READY:  wready_ff <= csr_chan.data[0];
               ddo_pkg::REG_START_X:       cur_x_ff  <= csr_chan.data;
               ddo_pkg::REG_START_Y:       cur_y_ff  <= csr_chan.data;
               ddo_pkg::REG_START_HEADING: cur_h_ff  <= csr_chan.data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pos_x      = out_x_ff;
   assign rsp_chan.pos_y      = out_y_ff;
   assign rsp_chan.heading    = out_h_ff;
   assign rsp_chan.moved      = out_moved_ff;
   assign rsp_chan.was_scaled = out_scaled_ff;
endmodule
`default_nettype wire

// ----- hdl/ddo_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, quotient saturated to 31 bits.
module ddo_div #(
   parameter int DW = 80
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DW-1:0]       dividend,
   input  wire logic [31:0]         divisor,
   output ddo_pkg::div_res_type     res
);
   localparam int QB = ddo_pkg::QUOT_BITS;
   localparam int NW = $clog2(QB + 1);

   logic [DW-1:0] rem_ff, dsr_ff;
   logic [QB-1:0] q_ff;
   logic          sat_ff, busy_ff, done_ff;
   logic [NW-1:0] cnt_ff;
   logic          take;

   assign take = (rem_ff >= dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == NW'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsr_ff <= DW'(divisor) << (QB - 1);
         // A quotient of 2^31 or more saturates.
         sat_ff <= (dividend >= (DW'(divisor) << QB));
         q_ff   <= '0;
         cnt_ff <= NW'(QB);
      end else if (busy_ff) begin
         if (take) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         q_ff   <= {q_ff[QB-2:0], take};
         dsr_ff <= dsr_ff >> 1;
         cnt_ff <= cnt_ff - NW'(1);
      end
   end

   assign res = {done_ff, (sat_ff ? ddo_pkg::MAG_MAX : q_ff)};
endmodule
`default_nettype wire

// ----- hdl/ddo_cordic.sv -----
`default_nettype none
// Rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic #(
   parameter int FRAC_BITS = 16,
   parameter int STEPS     = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [15:0]                 angle,
   output logic                             done,
   output logic signed [FRAC_BITS+2:0]      cos_o,
   output logic signed [FRAC_BITS+2:0]      sin_o
);
   localparam int     CW  = FRAC_BITS + 3;
   localparam int     IW  = $clog2(STEPS);
   localparam longint X0L = (ddo_pkg::GAIN_Q30 + (64'd1 << (29 - FRAC_BITS)))
                            >> (30 - FRAC_BITS);
   localparam logic signed [CW-1:0] X0   = CW'(X0L);
   localparam logic [IW-1:0]        LAST = IW'(STEPS - 1);
   localparam logic signed [33:0]   QTR  = 34'sd1073741824;
   localparam logic signed [33:0]   HALF = 34'sd2147483648;

   logic signed [CW-1:0] x_ff, y_ff, shx, shy;
   logic signed [33:0]   z_ff, z0, at;
   logic [IW-1:0]        i_ff;
   logic                 busy_ff, done_ff, flip_ff;

   assign z0  = {{2{angle[15]}}, angle, 16'd0};
   assign shx = x_ff >>> i_ff;
   assign shy = y_ff >>> i_ff;
   assign at  = {2'b00, ddo_pkg::atan_entry(5'(i_ff))};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && i_ff == LAST) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= X0;
         y_ff <= '0;
         i_ff <= '0;
         // Fold into the right half plane and fix the sign at the end.
         if (z0 > QTR) begin
            z_ff    <= z0 - HALF;
            flip_ff <= 1'b1;
         end else if (z0 < -QTR) begin
            z_ff    <= z0 + HALF;
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= z0;
            flip_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - shy;
            y_ff <= y_ff + shx;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + shy;
            y_ff <= y_ff - shx;
            z_ff <= z_ff + at;
         end
         i_ff <= i_ff + IW'(1);
      end
   end

   assign done  = done_ff;
   assign cos_o = flip_ff ? -x_ff : x_ff;
   assign sin_o = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

// ----- hdl/ddo_checker.sv -----
`default_nettype none
module ddo_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_moved,
   input wire logic rsp_was_scaled
);
   // A result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // Reset leaves no result pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held pose never reports scaling.
   a_scaled_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_moved |-> !rsp_was_scaled)
      else $error("scaling flagged on a held pose");

   // The block works on one command at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while busy");
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_moved      (rsp_chan.moved),
   .rsp_was_scaled (rsp_chan.was_scaled)
);
`default_nettype wire
